// ===== hdl/fekb_pkg.sv =====
// shared constants, codes and types for the keyed fifo-replacement buffer
`timescale 1ns / 1ps

package fekb_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int KEY_W        = 32;
  localparam int DATA_W       = 64;
  localparam int CFG_W        = 7;
  localparam int STATUS_W     = 3;
  localparam int EVCNT_W      = 32;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 2;

  localparam logic [CFG_W-1:0]  MAX_SIZE_RST  = 7'd64;
  localparam logic [APB_AW-1:0] MAX_SIZE_ADDR = 2'd0;

  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_DEL = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUT      = 3'd0,
    ST_EVICT    = 3'd1,
    ST_DEL_HIT  = 3'd2,
    ST_DEL_MISS = 3'd3,
    ST_DUP      = 3'd4
  } status_t;

  // per-slot compare results from the shared compare unit
  typedef struct packed {
    logic match;
    logic oldest;
    logic empty;
    logic above;
  } slot_cmp_t;

endpackage

// ===== hdl/fekb_slot_cmp.sv =====
// shared slot compare unit: key match, oldest, empty and rank-above tests
`timescale 1ns / 1ps

module fekb_slot_cmp import fekb_pkg::*; #(
  parameter int RW = 6
) (
  input  logic             valid,
  input  logic [KEY_W-1:0] slot_key,
  input  logic [RW-1:0]    slot_rank,
  input  logic [KEY_W-1:0] key,
  input  logic [RW-1:0]    drop_rank,
  output slot_cmp_t        res
);

  always_comb begin
    res.match  = valid && (slot_key == key);
    res.oldest = valid && (slot_rank == '0);
    res.empty  = !valid;
    res.above  = valid && (slot_rank > drop_rank);
  end

endmodule

// ===== hdl/fekb_slot_mem.sv =====
// slot storage: tag memory (valid, key, age rank) and payload memory
`timescale 1ns / 1ps

module fekb_slot_mem import fekb_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic [AW-1:0]     raddr,
  input  logic [AW-1:0]     waddr,
  input  logic              tag_we,
  input  logic              tag_wvalid,
  input  logic [KEY_W-1:0]  tag_wkey,
  input  logic [AW-1:0]     tag_wrank,
  input  logic              data_we,
  input  logic [DATA_W-1:0] data_wdata,
  output logic              tag_rvalid,
  output logic [KEY_W-1:0]  tag_rkey,
  output logic [AW-1:0]     tag_rrank,
  output logic [DATA_W-1:0] data_rdata
);

  localparam int TW = 1 + KEY_W + AW;

  logic [TW-1:0]     tag_mem  [CAPACITY];
  logic [DATA_W-1:0] data_mem [CAPACITY];
  logic [TW-1:0]     tag_rd;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[waddr] <= {tag_wvalid, tag_wkey, tag_wrank};
    end
    tag_rd <= tag_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[waddr] <= data_wdata;
    end
    data_rdata <= data_mem[raddr];
  end

  assign tag_rvalid = tag_rd[TW-1];
  assign tag_rkey   = tag_rd[TW-2 -: KEY_W];
  assign tag_rrank  = tag_rd[AW-1:0];

endmodule

// ===== hdl/fekb_ctrl.sv =====
// sequencer: clearing pass, slot scan, decision, payload fetch, rank renumber pass, store and result
`timescale 1ns / 1ps

module fekb_ctrl import fekb_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                kind,
  input  logic [KEY_W-1:0]    key,
  input  logic [DATA_W-1:0]   payload,
  input  logic [CFG_W-1:0]    max_size,
  output logic                busy,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [KEY_W-1:0]    out_key,
  output logic [DATA_W-1:0]   out_payload,
  output logic [EVCNT_W-1:0]  evicted_total,
  output logic [AW-1:0]       raddr,
  output logic [AW-1:0]       waddr,
  output logic                tag_we,
  output logic                tag_wvalid,
  output logic [KEY_W-1:0]    tag_wkey,
  output logic [AW-1:0]       tag_wrank,
  output logic                data_we,
  output logic [DATA_W-1:0]   data_wdata,
  input  logic                tag_rvalid,
  input  logic [KEY_W-1:0]    tag_rkey,
  input  logic [AW-1:0]       tag_rrank,
  input  logic [DATA_W-1:0]   data_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  typedef enum logic [9:0] {
    S_CLEAR      = 10'b0000000001,
    S_IDLE       = 10'b0000000010,
    S_SCAN       = 10'b0000000100,
    S_SCAN_LAST  = 10'b0000001000,
    S_DECIDE     = 10'b0000010000,
    S_FETCH      = 10'b0000100000,
    S_FETCH_WAIT = 10'b0001000000,
    S_RENUM      = 10'b0010000000,
    S_RENUM_LAST = 10'b0100000000,
    S_STORE      = 10'b1000000000
  } state_t;

  state_t state;

  logic [AW-1:0]      idx;
  logic               rd_pend;
  logic [AW-1:0]      pidx;
  logic               op_kind;
  logic [KEY_W-1:0]   op_key;
  logic [DATA_W-1:0]  op_payload;
  logic               hit_found;
  logic [AW-1:0]      hit_slot;
  logic [AW-1:0]      hit_rank;
  logic               old_found;
  logic [AW-1:0]      old_slot;
  logic [KEY_W-1:0]   old_key;
  logic               free_found;
  logic [AW-1:0]      free_slot;
  logic [AW-1:0]      drop_slot;
  logic [AW-1:0]      drop_rank;
  logic               evict;
  logic [DATA_W-1:0]  held_payload;
  logic [CW-1:0]      count;
  logic [EVCNT_W-1:0] evict_cnt;

  slot_cmp_t          cmp;
  logic [LW-1:0]      lim_raw;
  logic [LW-1:0]      lim_eff;
  logic               evict_need;
  logic               scan_stage;
  logic               renum_stage;

  fekb_slot_cmp #(.RW(AW)) u_cmp (
    .valid     (tag_rvalid),
    .slot_key  (tag_rkey),
    .slot_rank (tag_rrank),
    .key       (op_key),
    .drop_rank (drop_rank),
    .res       (cmp)
  );

  // effective limit is max_size clamped to 1..CAPACITY
  always_comb begin
    lim_raw = LW'(max_size);
    lim_eff = lim_raw;
    if (lim_raw == '0) begin
      lim_eff = LW'(1);
    end else if (lim_raw > LW'(CAPACITY)) begin
      lim_eff = LW'(CAPACITY);
    end
    evict_need = LW'(count) >= lim_eff;
  end

  assign scan_stage  = rd_pend && ((state == S_SCAN) || (state == S_SCAN_LAST));
  assign renum_stage = rd_pend && ((state == S_RENUM) || (state == S_RENUM_LAST));
  assign busy        = (state != S_IDLE);

  // memory port control
  always_comb begin
    raddr      = (state == S_FETCH) ? drop_slot : idx;
    waddr      = pidx;
    tag_we     = 1'b0;
    tag_wvalid = 1'b0;
    tag_wkey   = tag_rkey;
    tag_wrank  = tag_rrank;
    data_we    = 1'b0;
    data_wdata = op_payload;
    if (state == S_CLEAR) begin
      tag_we = 1'b1;
      waddr  = idx;
    end else if (renum_stage) begin
      // the dropped slot goes invalid, younger entries move up one rank
      if (pidx == drop_slot) begin
        tag_we = 1'b1;
      end else if (cmp.above) begin
        tag_we     = 1'b1;
        tag_wvalid = 1'b1;
        tag_wrank  = tag_rrank - AW'(1);
      end
    end else if ((state == S_STORE) && free_found) begin
      tag_we     = 1'b1;
      waddr      = free_slot;
      tag_wvalid = 1'b1;
      tag_wkey   = op_key;
      tag_wrank  = count[AW-1:0];
      data_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      rd_pend   <= 1'b0;
      done      <= 1'b0;
      count     <= '0;
      evict_cnt <= '0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;

      if (scan_stage) begin
        if (cmp.match && !hit_found) begin
          hit_found <= 1'b1;
          hit_slot  <= pidx;
          hit_rank  <= tag_rrank;
        end
        if (cmp.oldest && !old_found) begin
          old_found <= 1'b1;
          old_slot  <= pidx;
          old_key   <= tag_rkey;
        end
        if (cmp.empty && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= pidx;
        end
      end

      case (state)
        S_CLEAR: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            op_kind    <= kind;
            op_key     <= key;
            op_payload <= payload;
            hit_found  <= 1'b0;
            old_found  <= 1'b0;
            free_found <= 1'b0;
            idx        <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= 1'b1;
          pidx    <= idx;
          if (idx == LAST) begin
            state <= S_SCAN_LAST;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_SCAN_LAST: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          evict <= 1'b0;
          if (op_kind == KIND_DEL) begin
            if (hit_found) begin
              drop_slot <= hit_slot;
              drop_rank <= hit_rank;
              state     <= S_FETCH;
            end else begin
              done          <= 1'b1;
              status        <= ST_DEL_MISS;
              out_key       <= '0;
              out_payload   <= '0;
              evicted_total <= evict_cnt;
              state         <= S_IDLE;
            end
          end else if (hit_found) begin
            done          <= 1'b1;
            status        <= ST_DUP;
            out_key       <= '0;
            out_payload   <= '0;
            evicted_total <= evict_cnt;
            state         <= S_IDLE;
          end else if (evict_need && old_found) begin
            drop_slot <= old_slot;
            drop_rank <= '0;
            evict     <= 1'b1;
            // the victim slot may be the lowest free one after removal
            if (!free_found || (old_slot < free_slot)) begin
              free_found <= 1'b1;
              free_slot  <= old_slot;
            end
            state <= S_FETCH;
          end else begin
            state <= S_STORE;
          end
        end
        S_FETCH: begin
          state <= S_FETCH_WAIT;
        end
        S_FETCH_WAIT: begin
          held_payload <= data_rdata;
          idx          <= '0;
          state        <= S_RENUM;
        end
        S_RENUM: begin
          rd_pend <= 1'b1;
          pidx    <= idx;
          if (idx == LAST) begin
            state <= S_RENUM_LAST;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_RENUM_LAST: begin
          count <= count - CW'(1);
          if (evict) begin
            evict_cnt <= evict_cnt + EVCNT_W'(1);
            state     <= S_STORE;
          end else begin
            done          <= 1'b1;
            status        <= ST_DEL_HIT;
            out_key       <= op_key;
            out_payload   <= held_payload;
            evicted_total <= evict_cnt;
            state         <= S_IDLE;
          end
        end
        S_STORE: begin
          if (free_found) begin
            count <= count + CW'(1);
          end
          done          <= 1'b1;
          status        <= evict ? ST_EVICT : ST_PUT;
          out_key       <= evict ? old_key : '0;
          out_payload   <= evict ? held_payload : '0;
          evicted_total <= evict_cnt;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/fifo_evicting_keyed_buffer_core.sv =====
// top level: config register, sequencer and slot memories
//
//  channel   signals                              transfer when
//  command   start, kind, key, payload            start && !busy
//  result    done, status, out_key, out_payload,  done (one cycle, no stall)
//            evicted_total
//  config    psel, penable, pwrite, paddr,        psel && penable && pwrite
//            pwdata, prdata, pready
//
// every item scans all CAPACITY slots through the single tag read port, one slot
// per cycle; a delete miss or duplicate reports after the scan, a plain put after a
// store step, and a delete hit or an eviction adds a fetch and a rank renumber pass
// over the slots
// after reset a clearing pass over all CAPACITY slots invalidates every slot, busy high
// results cannot be held off; busy stays high until the result cycle
`timescale 1ns / 1ps

module fifo_evicting_keyed_buffer_core import fekb_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                kind,
  input  logic [KEY_W-1:0]    key,
  input  logic [DATA_W-1:0]   payload,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [KEY_W-1:0]    out_key,
  output logic [DATA_W-1:0]   out_payload,
  output logic [EVCNT_W-1:0]  evicted_total,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int AW = $clog2(CAPACITY);

  logic [CFG_W-1:0]  max_size;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic              tag_we;
  logic              tag_wvalid;
  logic [KEY_W-1:0]  tag_wkey;
  logic [AW-1:0]     tag_wrank;
  logic              data_we;
  logic [DATA_W-1:0] data_wdata;
  logic              tag_rvalid;
  logic [KEY_W-1:0]  tag_rkey;
  logic [AW-1:0]     tag_rrank;
  logic [DATA_W-1:0] data_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == MAX_SIZE_ADDR) ? {{(APB_DW-CFG_W){1'b0}}, max_size} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= MAX_SIZE_RST;
    end else if (psel && penable && pwrite && pready && (paddr == MAX_SIZE_ADDR)) begin
      max_size <= pwdata[CFG_W-1:0];
    end
  end

  fekb_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .kind          (kind),
    .key           (key),
    .payload       (payload),
    .max_size      (max_size),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .out_key       (out_key),
    .out_payload   (out_payload),
    .evicted_total (evicted_total),
    .raddr         (raddr),
    .waddr         (waddr),
    .tag_we        (tag_we),
    .tag_wvalid    (tag_wvalid),
    .tag_wkey      (tag_wkey),
    .tag_wrank     (tag_wrank),
    .data_we       (data_we),
    .data_wdata    (data_wdata),
    .tag_rvalid    (tag_rvalid),
    .tag_rkey      (tag_rkey),
    .tag_rrank     (tag_rrank),
    .data_rdata    (data_rdata)
  );

  fekb_slot_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk        (clk),
    .raddr      (raddr),
    .waddr      (waddr),
    .tag_we     (tag_we),
    .tag_wvalid (tag_wvalid),
    .tag_wkey   (tag_wkey),
    .tag_wrank  (tag_wrank),
    .data_we    (data_we),
    .data_wdata (data_wdata),
    .tag_rvalid (tag_rvalid),
    .tag_rkey   (tag_rkey),
    .tag_rrank  (tag_rrank),
    .data_rdata (data_rdata)
  );

endmodule

// ===== hdl/fekb_checker.sv =====
// port-level checks on the keyed buffer, bound to the top level
`timescale 1ns / 1ps

module fekb_checker import fekb_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [STATUS_W-1:0] status,
  input logic [KEY_W-1:0]    out_key,
  input logic [DATA_W-1:0]   out_payload
);

  // an accepted command keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // a result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work in progress");

  // one result per command, never two in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back results");

  // results that move no entry report zero key and payload
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_PUT || status == ST_DEL_MISS || status == ST_DUP))
      |-> (out_key == '0 && out_payload == '0))
    else $error("nonzero key or payload on a result that moves no entry");

endmodule

bind fifo_evicting_keyed_buffer_core fekb_checker u_fekb_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .out_key     (out_key),
  .out_payload (out_payload)
);

// ===== test/tb_fifo_evicting_keyed_buffer_core.sv =====
// testbench for the keyed fifo-replacement buffer: random put/delete commands checked by a shadow
`timescale 1ns / 1ps

module tb_fifo_evicting_keyed_buffer_core import fekb_pkg::*;;

  localparam int SLOTS = DEF_CAPACITY;
  localparam int POOL_MAX = 128;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 160;

  typedef struct {
    status_t             st;
    logic [KEY_W-1:0]    okey;
    logic [DATA_W-1:0]   opay;
    logic [EVCNT_W-1:0]  total;
  } outcome_t;

  // shadow copy of the slot store; predicts one outcome per accepted command
  class keyed_buffer_tracker;
    bit                 used [SLOTS];
    logic [KEY_W-1:0]   tag  [SLOTS];
    logic [DATA_W-1:0]  data [SLOTS];
    int                 age  [SLOTS];
    int                 held;
    logic [EVCNT_W-1:0] evictions;
    logic [CFG_W-1:0]   limit;
    outcome_t           outcomes[$];
    int                 fails;

    function new();
      foreach (used[i]) begin
        used[i] = 1'b0;
        tag[i]  = '0;
        data[i] = '0;
        age[i]  = 0;
      end
      held      = 0;
      evictions = '0;
      limit     = MAX_SIZE_RST;
      fails     = 0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      limit = v;
    endfunction

    // free a slot and close the gap in the insertion ages
    function void drop(int s);
      int r;
      r = age[s];
      used[s] = 1'b0;
      foreach (used[i])
        if (used[i] && age[i] > r) age[i]--;
      if (held > 0) held--;
    endfunction

    function void take_command(logic kd, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
      outcome_t o;
      int hit;
      int lim;
      int spot;
      bit gone;
      o.st   = ST_PUT;
      o.okey = '0;
      o.opay = '0;
      hit    = -1;
      spot   = -1;
      gone   = 1'b0;
      foreach (used[i])
        if (hit < 0 && used[i] && tag[i] == k) hit = i;
      if (kd == KIND_DEL) begin
        if (hit >= 0) begin
          o.st   = ST_DEL_HIT;
          o.okey = k;
          o.opay = data[hit];
          drop(hit);
        end else begin
          o.st = ST_DEL_MISS;
        end
      end else if (hit >= 0) begin
        o.st = ST_DUP;
      end else begin
        lim = int'(limit);
        if (lim < 1) lim = 1;
        if (lim > SLOTS) lim = SLOTS;
        if (held >= lim) begin
          foreach (used[i]) begin
            if (!gone && used[i] && age[i] == 0) begin
              o.okey = tag[i];
              o.opay = data[i];
              drop(i);
              evictions++;
              o.st = ST_EVICT;
              gone = 1'b1;
            end
          end
        end
        foreach (used[i])
          if (spot < 0 && !used[i]) spot = i;
        if (spot >= 0) begin
          used[spot] = 1'b1;
          tag[spot]  = k;
          data[spot] = d;
          age[spot]  = held;
          held++;
        end
      end
      o.total = evictions;
      outcomes.push_back(o);
    endfunction

    function void match_result(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] k,
                               logic [DATA_W-1:0] p, logic [EVCNT_W-1:0] tot);
      outcome_t o;
      if (outcomes.size() == 0) begin
        $display("%0t unexpected result: status %0d key %h payload %h total %0d",
                 $time, st, k, p, tot);
        fails++;
        return;
      end
      o = outcomes.pop_front();
      if (st !== o.st) begin
        $display("%0t status: expected %0d, got %0d", $time, o.st, st);
        fails++;
      end
      if (k !== o.okey) begin
        $display("%0t out_key: expected %h, got %h", $time, o.okey, k);
        fails++;
      end
      if (p !== o.opay) begin
        $display("%0t out_payload: expected %h, got %h", $time, o.opay, p);
        fails++;
      end
      if (tot !== o.total) begin
        $display("%0t evicted_total: expected %0d, got %0d", $time, o.total, tot);
        fails++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst     = 1'b1;
  logic                start   = 1'b0;
  logic                kind    = 1'b0;
  logic [KEY_W-1:0]    key     = '0;
  logic [DATA_W-1:0]   payload = '0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [APB_AW-1:0]   paddr   = '0;
  logic [APB_DW-1:0]   pwdata  = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    out_key;
  logic [DATA_W-1:0]   out_payload;
  logic [EVCNT_W-1:0]  evicted_total;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  keyed_buffer_tracker shadow = new();
  bit                  steady = 1'b0;
  logic [KEY_W-1:0]    key_pool [POOL_MAX];

  fifo_evicting_keyed_buffer_core u_top (
    .clk, .rst, .start, .busy, .kind, .key, .payload,
    .done, .status, .out_key, .out_payload, .evicted_total,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // results are checked before a command taken at the same edge is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (done) shadow.match_result(status, out_key, out_payload, evicted_total);
      if (start && !busy) shadow.take_command(kind, key, payload);
    end
  end

  task automatic issue(input logic kd, input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] d);
    int g;
    int r;
    start   <= 1'b1;
    kind    <= kd;
    key     <= k;
    payload <= d;
    do @(posedge clk); while (busy);
    r = $urandom_range(0, 99);
    if (steady || r < 45) g = 0;
    else if (r < 88) g = $urandom_range(1, 4);
    else if (r < 97) g = $urandom_range(5, 40);
    else g = $urandom_range(41, 200);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    // busy from the last transfer is not yet seen at the edge that took it
    @(posedge clk);
    while (shadow.outcomes.size() != 0 || busy) @(posedge clk);
  endtask

  // write max_size, then read it back
  task automatic write_limit(input int lim);
    logic [APB_DW-1:0] w;
    logic [APB_DW-1:0] want;
    w = APB_DW'(lim);
    if ($urandom_range(0, 1) == 1) w = w | ($urandom & ~32'h7f);
    want = '0;
    want[CFG_W-1:0] = w[CFG_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_SIZE_ADDR;
    pwdata  <= w;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow.set_limit(w[CFG_W-1:0]);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t max_size readback: expected %h, got %h", $time, want, prdata);
      shadow.fails++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int phase_limit [PHASES];
    int eff;
    int n;
    int put_pct;
    logic kd;
    logic [KEY_W-1:0] k;

    phase_limit = '{64, 1, 2, 0, 127, 3, 65, 8, 5, 64, 33, 100};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty buffer, key and payload extremes, duplicate, hit and miss
    issue(KIND_DEL, 32'h0, 64'h0123_4567_89ab_cdef);
    issue(KIND_PUT, 32'h0, 64'h0);
    issue(KIND_PUT, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    issue(KIND_PUT, 32'h0, 64'h5555_5555_5555_5555);
    issue(KIND_DEL, 32'hffff_ffff, 64'h0);
    issue(KIND_DEL, 32'hffff_ffff, 64'h0);
    issue(KIND_PUT, 32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa);
    issue(KIND_PUT, 32'h8000_0001, 64'h8000_0000_0000_0001);
    issue(KIND_PUT, 32'h7fff_fffe, 64'h7fff_ffff_ffff_fffe);
    drain_results();
    // limit now below occupancy, and a re-put key must count as newest
    write_limit(2);
    issue(KIND_PUT, 32'h10, 64'h10);
    issue(KIND_DEL, 32'h8000_0001, 64'h0);
    issue(KIND_PUT, 32'h8000_0001, 64'h11);
    issue(KIND_PUT, 32'h20, 64'h20);
    drain_results();
    write_limit(0);
    issue(KIND_PUT, 32'h30, 64'h30);
    issue(KIND_DEL, 32'h10, 64'h0);
    issue(KIND_PUT, 32'h10, 64'h31);
    drain_results();
    write_limit(127);
    issue(KIND_PUT, 32'h40, 64'h40);
    issue(KIND_PUT, 32'h50, 64'h50);
    issue(KIND_DEL, 32'h30, 64'h0);
    issue(KIND_PUT, 32'h30, 64'h51);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_limit(phase_limit[ph]);
      eff = phase_limit[ph];
      if (eff < 1) eff = 1;
      if (eff > SLOTS) eff = SLOTS;
      n = eff + $urandom_range(2, eff + 4);
      if (n > POOL_MAX) n = POOL_MAX;
      put_pct = $urandom_range(55, 85);
      for (int i = 0; i < n; i++) key_pool[i] = $urandom;
      if ($urandom_range(0, 1) == 1) begin
        key_pool[0] = '0;
        key_pool[1] = '1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 59) == 0) drain_results();
        kd = ($urandom_range(0, 99) < put_pct) ? KIND_PUT : KIND_DEL;
        k = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(0, n - 1)];
        issue(kd, k, {$urandom, $urandom});
      end
    end

    drain_results();
    repeat (300) @(posedge clk);
    if (shadow.fails == 0 && shadow.outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/fekb_pkg.sv
hdl/fekb_slot_cmp.sv
hdl/fekb_slot_mem.sv
hdl/fekb_ctrl.sv
hdl/fifo_evicting_keyed_buffer_core.sv
hdl/fekb_checker.sv
test/tb_fifo_evicting_keyed_buffer_core.sv
